FILE: hdl/salkc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// salkc_pkg
// Shared constants and types for the set associative lru key cache: sizing,
// derived widths, the lookup and result beats, the entry word and the
// sequencer states.
// ----------------------------------------------------------------------------
package salkc_pkg;

    // sizing
    localparam int NUM_SETS = 64;
    localparam int WAYS     = 4;
    localparam int KEY_BITS = 32;

    // derived widths
    localparam int SET_BITS = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W    = $clog2(WAYS);
    localparam int FILL_W   = $clog2(WAYS + 1);
    localparam int ENTRIES  = NUM_SETS * WAYS;
    localparam int ENT_AW   = $clog2(ENTRIES);
    localparam int ENT_W    = KEY_BITS + 1 + WAY_W;
    localparam int BIT_CW   = $clog2(KEY_BITS);

    // set index by masking when the set count is a power of two
    localparam bit SET_POW2 = ((NUM_SETS & (NUM_SETS - 1)) == 0);
    localparam logic [SET_BITS-1:0] SET_MASK = SET_BITS'(NUM_SETS - 1);

    // lookup beat
    typedef struct packed {
        logic [31:0] lookup_key;
        logic        mark_modified;
    } lookup_t;

    // result beat
    typedef struct packed {
        logic        was_hit;
        logic        needs_writeback;
        logic [31:0] victim_key;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] writeback_total;
    } result_t;

    // one way of a set as held in the entry memory
    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic                dirty;
        logic [WAY_W-1:0]    rank;
    } entry_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_FILL,
        ST_SCAN_RD,
        ST_SCAN,
        ST_UPD_RD,
        ST_UPD,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

FILE: hdl/set_assoc_lru_key_cache.sv
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_lru_key_cache
// Set associative key cache with lru replacement and dirty marks. A small
// sequencer walks the ways of one set through the entry memory, one way per
// cycle, first to search and then to rewrite age ranks and the new entry.
// ----------------------------------------------------------------------------
// sequence: a lookup reads the set's fill count, scans its ways, rewrites
//   their ranks and the new entry and strobes the result; a non power of two
//   set count first adds a bit serial pass for the set index remainder
// occupancy: a lookup is taken only when idle, so a new one waits until the
//   last result is out; busy is high meanwhile
// reset: a clearing sweep zeroes the fill count of every set with busy
//   high; results are single-cycle strobes and the receiver cannot stall
module set_assoc_lru_key_cache
    import salkc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire lookup_t lookup,
    output logic         busy,
    output logic         done,
    output result_t      result
);

    // sequencer and datapath registers
    state_t              state_reg, state_next;
    logic [SET_BITS-1:0] set_reg, set_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [KEY_BITS-1:0] src_reg, src_next;
    logic [BIT_CW-1:0]   bit_cnt_reg, bit_cnt_next;
    logic                mod_reg, mod_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [WAY_W-1:0]    way_reg, way_next;
    logic                hit_reg, hit_next;
    logic [WAY_W-1:0]    hit_way_reg, hit_way_next;
    logic [WAY_W-1:0]    hit_rank_reg, hit_rank_next;
    logic [WAY_W-1:0]    vic_way_reg, vic_way_next;
    logic [WAY_W-1:0]    vic_rank_reg, vic_rank_next;
    logic [KEY_BITS-1:0] vic_key_reg, vic_key_next;
    logic                vic_dirty_reg, vic_dirty_next;
    logic [31:0]         hit_cnt_reg, hit_cnt_next;
    logic [31:0]         miss_cnt_reg, miss_cnt_next;
    logic [31:0]         wb_cnt_reg, wb_cnt_next;

    // memory ports
    logic                fill_we;
    logic [FILL_W-1:0]   fill_wdata;
    logic [FILL_W-1:0]   fill_rdata;
    logic                ent_we;
    logic [ENT_AW-1:0]   ent_waddr;
    logic [ENT_AW-1:0]   ent_raddr;
    logic [ENT_W-1:0]    ent_wdata;
    logic [ENT_W-1:0]    ent_rdata;
    logic [WAY_W-1:0]    rd_way;

    // shared decode
    entry_t              ent_rd;
    entry_t              ent_new;
    logic [ENT_AW-1:0]   ent_base;
    logic                set_full;
    logic                grow;
    logic                wb_flag;
    logic [WAY_W-1:0]    tgt_way;
    logic [WAY_W-1:0]    last_way;
    logic [WAY_W-1:0]    last_scan;
    logic                key_match;
    logic [SET_BITS:0]   rem_sh;
    logic                rem_ge;

    assign ent_rd    = entry_t'(ent_rdata);
    assign ent_base  = ENT_AW'(set_reg) * ENT_AW'(WAYS);
    assign set_full  = (fill_reg == FILL_W'(WAYS));
    assign grow      = !hit_reg && !set_full;
    assign wb_flag   = !hit_reg && set_full && vic_dirty_reg;
    assign tgt_way   = hit_reg ? hit_way_reg : (grow ? WAY_W'(fill_reg) : vic_way_reg);
    assign last_way  = grow ? WAY_W'(fill_reg) : WAY_W'(fill_reg - 1'b1);
    assign last_scan = WAY_W'(fill_reg - 1'b1);
    assign key_match = (ent_rd.key == key_reg);

    // one bit of the set index remainder
    assign rem_sh = {set_reg, src_reg[KEY_BITS-1]};
    assign rem_ge = (rem_sh >= (SET_BITS + 1)'(NUM_SETS));

    // fill count per set
    salkc_ram #(
        .WIDTH (FILL_W),
        .DEPTH (NUM_SETS)
    ) u_fill_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (set_reg),
        .wdata (fill_wdata),
        .raddr (set_reg),
        .rdata (fill_rdata)
    );

    // key, dirty mark and age rank per way
    salkc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (set_reg == SET_BITS'(NUM_SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = SET_POW2 ? ST_FILL : ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (bit_cnt_reg == BIT_CW'(KEY_BITS - 1))
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                state_next = ST_SCAN_RD;
            end
            ST_SCAN_RD:
            begin
                state_next = (fill_rdata == '0) ? ST_UPD_RD : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (key_match || (way_reg == last_scan))
                begin
                    state_next = ST_UPD_RD;
                end
            end
            ST_UPD_RD:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (way_reg == last_way)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        set_next       = set_reg;
        key_next       = key_reg;
        src_next       = src_reg;
        bit_cnt_next   = bit_cnt_reg;
        mod_next       = mod_reg;
        fill_next      = fill_reg;
        way_next       = way_reg;
        hit_next       = hit_reg;
        hit_way_next   = hit_way_reg;
        hit_rank_next  = hit_rank_reg;
        vic_way_next   = vic_way_reg;
        vic_rank_next  = vic_rank_reg;
        vic_key_next   = vic_key_reg;
        vic_dirty_next = vic_dirty_reg;
        hit_cnt_next   = hit_cnt_reg;
        miss_cnt_next  = miss_cnt_reg;
        wb_cnt_next    = wb_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                set_next = set_reg + 1'b1;
                if (set_reg == SET_BITS'(NUM_SETS - 1))
                begin
                    set_next = '0;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    key_next     = KEY_BITS'(lookup.lookup_key);
                    src_next     = KEY_BITS'(lookup.lookup_key);
                    mod_next     = lookup.mark_modified;
                    bit_cnt_next = '0;
                    hit_next     = 1'b0;
                    set_next     = SET_POW2
                                 ? (SET_BITS'(KEY_BITS'(lookup.lookup_key)) & SET_MASK)
                                 : '0;
                end
            end
            ST_MOD:
            begin
                // restoring remainder, key msb first
                set_next     = rem_ge ? SET_BITS'(rem_sh - (SET_BITS + 1)'(NUM_SETS))
                                      : SET_BITS'(rem_sh);
                src_next     = src_reg << 1;
                bit_cnt_next = bit_cnt_reg + 1'b1;
            end
            ST_SCAN_RD:
            begin
                fill_next = fill_rdata;
                way_next  = '0;
            end
            ST_SCAN:
            begin
                // first key match wins
                if (key_match)
                begin
                    hit_next      = 1'b1;
                    hit_way_next  = way_reg;
                    hit_rank_next = ent_rd.rank;
                end
                // oldest way, lowest way on ties
                if ((way_reg == '0) || (ent_rd.rank > vic_rank_reg))
                begin
                    vic_way_next   = way_reg;
                    vic_rank_next  = ent_rd.rank;
                    vic_key_next   = ent_rd.key;
                    vic_dirty_next = ent_rd.dirty;
                end
                way_next = way_reg + 1'b1;
            end
            ST_UPD_RD:
            begin
                way_next = '0;
                if (hit_reg)
                begin
                    hit_cnt_next = hit_cnt_reg + 1'b1;
                end
                else
                begin
                    miss_cnt_next = miss_cnt_reg + 1'b1;
                end
                if (wb_flag)
                begin
                    wb_cnt_next = wb_cnt_reg + 1'b1;
                end
            end
            ST_UPD:
            begin
                way_next = way_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // rewritten entry for the way read back in the update pass
    always_comb
    begin
        ent_new = ent_rd;
        if (way_reg == tgt_way)
        begin
            ent_new.key   = key_reg;
            ent_new.dirty = hit_reg ? (ent_rd.dirty | mod_reg) : mod_reg;
            ent_new.rank  = '0;
        end
        else if (!hit_reg || (ent_rd.rank < hit_rank_reg))
        begin
            ent_new.rank = ent_rd.rank + 1'b1;
        end
    end

    // state outputs and memory controls
    always_comb
    begin
        busy       = (state_reg != ST_IDLE);
        done       = (state_reg == ST_DONE);
        fill_we    = 1'b0;
        fill_wdata = '0;
        ent_we     = 1'b0;
        rd_way     = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                fill_we = 1'b1;
            end
            ST_SCAN, ST_UPD:
            begin
                rd_way = way_reg + 1'b1;
                ent_we = (state_reg == ST_UPD);
            end
            ST_UPD_RD:
            begin
                fill_we    = grow;
                fill_wdata = fill_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
        ent_raddr = ent_base + ENT_AW'(rd_way);
        ent_waddr = ent_base + ENT_AW'(way_reg);
        ent_wdata = ent_new;

        result.was_hit         = hit_reg;
        result.needs_writeback = wb_flag;
        result.victim_key      = wb_flag ? 32'(vic_key_reg) : '0;
        result.hit_total       = hit_cnt_reg;
        result.miss_total      = miss_cnt_reg;
        result.writeback_total = wb_cnt_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            set_reg      <= '0;
            bit_cnt_reg  <= '0;
            way_reg      <= '0;
            hit_reg      <= 1'b0;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            wb_cnt_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            set_reg      <= set_next;
            bit_cnt_reg  <= bit_cnt_next;
            way_reg      <= way_next;
            hit_reg      <= hit_next;
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
            wb_cnt_reg   <= wb_cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        src_reg       <= src_next;
        mod_reg       <= mod_next;
        fill_reg      <= fill_next;
        hit_way_reg   <= hit_way_next;
        hit_rank_reg  <= hit_rank_next;
        vic_way_reg   <= vic_way_next;
        vic_rank_reg  <= vic_rank_next;
        vic_key_reg   <= vic_key_next;
        vic_dirty_reg <= vic_dirty_next;
    end

    // fill count read back never exceeds the way count
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN_RD) |-> (fill_rdata <= FILL_W'(WAYS)))
        else $error("fill count above way count");

    // a single strobe per lookup
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // write-back only on a miss
    a_wb_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.needs_writeback) |-> !result.was_hit)
        else $error("write-back reported on a hit");

    // an accepted beat makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("lookup accepted without going busy");

    // hit and miss totals together move by one per lookup
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD_RD) |=> ((hit_cnt_reg + miss_cnt_reg)
                  == ($past(hit_cnt_reg + miss_cnt_reg) + 32'd1)))
        else $error("hit and miss totals moved by other than one");

endmodule
`default_nettype wire

FILE: hdl/salkc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// salkc_ram
// Generic simple dual port memory: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module salkc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire
